// ===== sv/nlma_pkg.sv =====
package nlma_pkg;

  localparam int NCH            = 9;
  localparam int CH_W           = 16;
  localparam int CH_IDX_W       = 4;
  localparam int ALPHA_W        = 9;
  localparam int WINDOW_DEF     = 16;
  localparam int ALPHA_FRAC_DEF = 8;

  // quotient bits retired per divider cycle
  localparam int DIV_STEP       = 4;

  localparam int CH_MAX         = 32767;

  localparam logic [CH_IDX_W-1:0] CH_GYRO_LO = CH_IDX_W'(3);
  localparam logic [CH_IDX_W-1:0] CH_MAG_LO  = CH_IDX_W'(6);
  localparam logic [CH_IDX_W-1:0] CH_LAST    = CH_IDX_W'(NCH - 1);

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_AM   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_GYRO = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAG_EN     = 2'd2;

  localparam logic [ALPHA_W-1:0] ALPHA_AM_RST   = 9'd166;
  localparam logic [ALPHA_W-1:0] ALPHA_GYRO_RST = 9'd128;

endpackage

// ===== sv/nlma_div.sv =====
module nlma_div #(
  parameter int SUM_W = 21,
  parameter int CNT_W = 5
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic signed [SUM_W-1:0]        sum_i,
  input  logic        [CNT_W-1:0]        count_i,
  output logic                           done_o,
  output logic signed [nlma_pkg::CH_W-1:0] avg_o
);
  import nlma_pkg::*;

  localparam int NUM_W = SUM_W + 1;
  localparam int D_W   = CNT_W + 1;
  localparam int ITER  = (NUM_W + DIV_STEP - 1) / DIV_STEP;
  localparam int PAD_W = ITER * DIV_STEP;
  localparam int IT_W  = $clog2(ITER + 1);

  logic [PAD_W-1:0] num_q, num_d, quo_q, quo_d;
  logic [D_W-1:0]   rem_q, rem_d, den_q;
  logic [IT_W-1:0]  cnt_q;
  logic             busy_q, done_q, neg_q;
  logic [SUM_W-1:0] mag;
  logic [NUM_W-1:0] num_init;

  // numerator 2|sum| + n over denominator 2n rounds to nearest, ties away
  assign mag      = sum_i[SUM_W-1] ? (~sum_i + 1'b1) : sum_i;
  assign num_init = {mag, 1'b0} + NUM_W'(count_i);

  always_comb begin
    logic [D_W:0]     rs;
    logic [D_W-1:0]   r;
    logic [PAD_W-1:0] nn;
    logic [PAD_W-1:0] qq;
    r  = rem_q;
    nn = num_q;
    qq = quo_q;
    for (int k = 0; k < DIV_STEP; k++) begin
      rs = {r, nn[PAD_W-1]};
      nn = {nn[PAD_W-2:0], 1'b0};
      if (rs >= {1'b0, den_q}) begin
        rs = rs - {1'b0, den_q};
        qq = {qq[PAD_W-2:0], 1'b1};
      end else begin
        qq = {qq[PAD_W-2:0], 1'b0};
      end
      r = rs[D_W-1:0];
    end
    rem_d = r;
    num_d = nn;
    quo_d = qq;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (start_i) begin
        busy_q <= 1'b1;
        done_q <= 1'b0;
        cnt_q  <= IT_W'(ITER);
      end else if (busy_q) begin
        cnt_q  <= cnt_q - 1'b1;
        done_q <= (cnt_q == IT_W'(1));
        if (cnt_q == IT_W'(1)) busy_q <= 1'b0;
      end else begin
        done_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= PAD_W'(num_init);
      rem_q <= '0;
      quo_q <= '0;
      den_q <= {count_i, 1'b0};
      neg_q <= sum_i[SUM_W-1];
    end else if (busy_q) begin
      num_q <= num_d;
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  always_comb begin
    if (neg_q) begin
      if (quo_q > PAD_W'(CH_MAX + 1)) avg_o = {1'b1, {(CH_W-1){1'b0}}};
      else                           avg_o = -quo_q[CH_W-1:0];
    end else begin
      if (quo_q > PAD_W'(CH_MAX)) avg_o = {1'b0, {(CH_W-1){1'b1}}};
      else                       avg_o = quo_q[CH_W-1:0];
    end
  end

  assign done_o = done_q;

endmodule

// ===== sv/nine_axis_lowpass_moving_average.sv =====
// Nine-channel smoother: per-channel first-order low-pass, then a moving
// average over the last WINDOW filtered samples.
// Input stream (s_axis_*): one beat carries one sample of nine signed 16-bit
// channels. Output stream (m_axis_*): one beat per input beat with the nine
// rounded averages. Config channel (cfg_*): index 0 alpha_accel_mag,
// 1 alpha_gyro, 2 mag_enable; always ready, write only while idle.
// One sample at a time: each channel in turn is read, multiplied twice
// on one shared multiplier, rounded, accumulated and then averaged by
// the divider with ITER = ceil((SUM_W+1)/DIV_STEP) steps; a frozen mag
// channel skips the second multiply, the rounding and the accumulate.
// The channel loop over the state memory and the divider sets the
// sample rate, with mag on or off.
// Reset clears the filter state through valid bits, the ring position and
// the fill counts; the ring memory itself is not cleared.
// A stalled receiver holds the finished beat in the output register; the
// next sample is still accepted and runs until its result needs that
// register.
module nine_axis_lowpass_moving_average #(
  parameter int WINDOW          = nlma_pkg::WINDOW_DEF,
  parameter int ALPHA_FRAC_BITS = nlma_pkg::ALPHA_FRAC_DEF
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, mag_x, mag_y, mag_z
  input  logic [nlma_pkg::NCH*nlma_pkg::CH_W-1:0]    s_axis_tdata,
  input  logic                                       s_axis_tvalid,
  output logic                                       s_axis_tready,
  // avg_accel_x, avg_accel_y, avg_accel_z, avg_gyro_x, avg_gyro_y,
  // avg_gyro_z, avg_mag_x, avg_mag_y, avg_mag_z
  output logic [nlma_pkg::NCH*nlma_pkg::CH_W-1:0]    m_axis_tdata,
  output logic                                       m_axis_tvalid,
  input  logic                                       m_axis_tready,
  input  logic                                       cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  logic [nlma_pkg::CFG_IDX_W-1:0]             cfg_index_i,
  input  logic [nlma_pkg::ALPHA_W-1:0]               cfg_data_i
);
  import nlma_pkg::*;

  localparam int F     = ALPHA_FRAC_BITS;
  localparam int S_W   = CH_W + F;
  localparam int AW    = (F + 1 > ALPHA_W) ? F + 1 : ALPHA_W;
  localparam int P_W   = AW + 1 + S_W;
  localparam int SUM_W = CH_W + $clog2(WINDOW) + 1;
  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int SL_W  = $clog2(WINDOW);
  localparam int WA_W  = $clog2(NCH * WINDOW);
  localparam int WDEP  = NCH * WINDOW;

  localparam logic [AW-1:0]         ONE_A  = AW'(1) << F;
  localparam logic signed [P_W:0]   HALF_P = (P_W + 1)'(1) << (F - 1);
  localparam logic signed [S_W:0]   HALF_S = (S_W + 1)'(1) << (F - 1);
  localparam logic [CNT_W-1:0]      WIN_C  = CNT_W'(WINDOW);
  localparam logic [SL_W-1:0]       SL_END = SL_W'(WINDOW - 1);
  localparam logic [WA_W-1:0]       WIN_A  = WA_W'(WINDOW);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_RD   = 9'b000000010,
    S_MUL1 = 9'b000000100,
    S_MUL2 = 9'b000001000,
    S_ACC  = 9'b000010000,
    S_VAL  = 9'b000100000,
    S_PUSH = 9'b001000000,
    S_DIV  = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [ALPHA_W-1:0] alpha_am_q, alpha_gyro_q;
  logic               mag_en_q;

  // control
  logic [CH_IDX_W-1:0] ch_q;
  logic [WA_W-1:0]     base_q;
  logic [SL_W-1:0]     slot_q;
  logic [CNT_W-1:0]    filled_q, mag_filled_q;
  logic [CNT_W-1:0]    n_main_q, n_mag_q;
  logic                full_q, mag_full_q;
  logic [NCH-1:0]      st_vld_q;
  logic                m_valid_q;

  // payload
  logic signed [CH_W-1:0]  in_q  [NCH];
  logic signed [CH_W-1:0]  res_q [NCH];
  logic [NCH*CH_W-1:0]     m_data_q;
  logic signed [P_W-1:0]   p1_q, p2_q;
  logic signed [S_W-1:0]   s_new_q;
  logic signed [CH_W-1:0]  v_q, old_q;
  logic signed [SUM_W-1:0] sum_q;

  // memories
  logic [S_W+SUM_W-1:0] st_mem [NCH];
  logic [S_W+SUM_W-1:0] st_rd_q;
  logic [CH_W-1:0]      win_mem [WDEP];
  logic [CH_W-1:0]      win_rd_q;

  logic                    in_acc, load_out, is_mag, frozen, ch_full, st_we;
  logic [WA_W-1:0]         win_addr;
  logic [ALPHA_W-1:0]      a_sel;
  logic [AW-1:0]           a_ext, a_sat;
  logic signed [P_W-1:0]   mul_a, mul_b, mul_p;
  logic signed [S_W-1:0]   s_old;
  logic signed [P_W:0]     acc;
  logic signed [S_W:0]     t_val, t_neg;
  logic signed [CH_W:0]    v_wide;
  logic signed [SUM_W:0]   sum_wide;
  logic signed [SUM_W-1:0] sum_new, div_sum;
  logic [CNT_W-1:0]        div_cnt, n_main_d, n_mag_d;
  logic                    div_done;
  logic signed [CH_W-1:0]  div_avg;

  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign load_out      = (state_q == S_OUT) && (!m_valid_q || m_axis_tready);
  assign cfg_ready_o   = 1'b1;

  assign is_mag   = (ch_q >= CH_MAG_LO);
  assign frozen   = is_mag && !mag_en_q;
  assign ch_full  = is_mag ? mag_full_q : full_q;
  assign win_addr = base_q + WA_W'(slot_q);
  assign st_we    = (state_q == S_PUSH) && !frozen;

  // ---------------------------------------------------------------------
  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_am_q   <= ALPHA_AM_RST;
      alpha_gyro_q <= ALPHA_GYRO_RST;
      mag_en_q     <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_ALPHA_AM:   alpha_am_q   <= cfg_data_i;
        CFG_ALPHA_GYRO: alpha_gyro_q <= cfg_data_i;
        CFG_MAG_EN:     mag_en_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_acc) state_d = S_RD;
      S_RD:   state_d = S_MUL1;
      S_MUL1: state_d = frozen ? S_PUSH : S_MUL2;
      S_MUL2: state_d = S_ACC;
      S_ACC:  state_d = S_VAL;
      S_VAL:  state_d = S_PUSH;
      S_PUSH: state_d = S_DIV;
      S_DIV: begin
        if (div_done) state_d = (ch_q == CH_LAST) ? S_OUT : S_RD;
      end
      S_OUT:  if (load_out) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // averages use the counts as they stand after this sample
  always_comb begin
    n_main_d = (filled_q >= WIN_C) ? WIN_C : filled_q + 1'b1;
    if (mag_en_q)              n_mag_d = (mag_filled_q >= WIN_C) ? WIN_C : mag_filled_q + 1'b1;
    else if (mag_filled_q == '0) n_mag_d = CNT_W'(1);
    else                       n_mag_d = mag_filled_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      ch_q         <= '0;
      base_q       <= '0;
      slot_q       <= '0;
      filled_q     <= '0;
      mag_filled_q <= '0;
      n_main_q     <= '0;
      n_mag_q      <= '0;
      full_q       <= 1'b0;
      mag_full_q   <= 1'b0;
      st_vld_q     <= '0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        ch_q       <= '0;
        base_q     <= '0;
        full_q     <= (filled_q >= WIN_C);
        mag_full_q <= (mag_filled_q >= WIN_C);
        n_main_q   <= n_main_d;
        n_mag_q    <= n_mag_d;
      end
      if (st_we) st_vld_q[ch_q] <= 1'b1;
      if ((state_q == S_DIV) && div_done && (ch_q != CH_LAST)) begin
        ch_q   <= ch_q + 1'b1;
        base_q <= base_q + WIN_A;
      end
      if (load_out) begin
        slot_q <= (slot_q == SL_END) ? '0 : slot_q + 1'b1;
        if (!full_q) filled_q <= filled_q + 1'b1;
        if (mag_en_q && !mag_full_q) mag_filled_q <= mag_filled_q + 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // state memories; each channel is written back before the next channel
  // is read, so no two accesses to one entry overlap
  always_ff @(posedge clk_i) begin
    if (st_we) st_mem[ch_q] <= {s_new_q, sum_new};
    if (state_q == S_RD) st_rd_q <= st_mem[ch_q];
  end

  always_ff @(posedge clk_i) begin
    if (st_we) win_mem[win_addr] <= v_q;
    if (state_q == S_RD) win_rd_q <= win_mem[win_addr];
  end

  // ---------------------------------------------------------------------
  // datapath
  always_comb begin
    a_sel = ((ch_q < CH_GYRO_LO) || is_mag) ? alpha_am_q : alpha_gyro_q;
    a_ext = AW'(a_sel);
    // saturate the weight to one
    a_sat = (a_ext > ONE_A) ? ONE_A : a_ext;
    s_old = st_vld_q[ch_q] ? signed'(st_rd_q[S_W+SUM_W-1:SUM_W]) : '0;
    // one multiplier: a*s first, then (ONE-a)*x
    if (state_q == S_MUL1) begin
      mul_a = P_W'(signed'({1'b0, a_sat}));
      mul_b = P_W'(s_old);
    end else begin
      mul_a = P_W'(signed'({1'b0, ONE_A - a_sat}));
      mul_b = P_W'(in_q[ch_q]);
    end
    mul_p = mul_a * mul_b;
  end

  assign acc = (P_W + 1)'(p1_q) + ((P_W + 1)'(p2_q) <<< F) + HALF_P;

  // add one half, truncate toward zero, clamp to 16 bits
  always_comb begin
    t_val = (S_W + 1)'(s_new_q) + HALF_S;
    t_neg = -t_val;
    if (!t_val[S_W]) v_wide = (CH_W + 1)'(t_val >>> F);
    else             v_wide = -((CH_W + 1)'(t_neg >>> F));
  end

  assign sum_wide = (SUM_W + 1)'(sum_q)
                  - (ch_full ? (SUM_W + 1)'(old_q) : '0)
                  + (SUM_W + 1)'(v_q);
  assign sum_new  = sum_wide[SUM_W-1:0];
  assign div_sum  = frozen ? sum_q : sum_new;
  assign div_cnt  = is_mag ? n_mag_q : n_main_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      for (int i = 0; i < NCH; i++) in_q[i] <= s_axis_tdata[i*CH_W +: CH_W];
    end
    if (state_q == S_MUL1) begin
      p1_q  <= mul_p;
      sum_q <= st_vld_q[ch_q] ? signed'(st_rd_q[SUM_W-1:0]) : '0;
      old_q <= signed'(win_rd_q);
    end
    if (state_q == S_MUL2) p2_q <= mul_p;
    if (state_q == S_ACC)  s_new_q <= S_W'(acc >>> F);
    if (state_q == S_VAL) begin
      if (v_wide > (CH_W + 1)'(CH_MAX))            v_q <= {1'b0, {(CH_W-1){1'b1}}};
      else if (v_wide < -((CH_W + 1)'(CH_MAX) + 1)) v_q <= {1'b1, {(CH_W-1){1'b0}}};
      else                                         v_q <= v_wide[CH_W-1:0];
    end
    if ((state_q == S_DIV) && div_done) res_q[ch_q] <= div_avg;
  end

  nlma_div #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == S_PUSH),
    .sum_i   (div_sum),
    .count_i (div_cnt),
    .done_o  (div_done),
    .avg_o   (div_avg)
  );

  // ---------------------------------------------------------------------
  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (load_out) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      for (int i = 0; i < NCH; i++) m_data_q[i*CH_W +: CH_W] <= res_q[i];
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

// ===== sv/nlma_checker.sv =====
module nlma_checker (
  input logic                                    clk_i,
  input logic                                    rst_ni,
  input logic                                    s_axis_tvalid,
  input logic                                    s_axis_tready,
  input logic                                    m_axis_tvalid,
  input logic                                    m_axis_tready,
  input logic [nlma_pkg::NCH*nlma_pkg::CH_W-1:0] m_axis_tdata
);

  // hold a stalled output beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output beat changed");

  // one sample at a time: an accepted beat is followed by a busy spell
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready ##1 !s_axis_tready)
    else $error("input accepted while a sample is in progress");

  // a result appears as the block returns to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> s_axis_tready)
    else $error("result delivered without returning to idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared without a sample in progress");

endmodule

bind nine_axis_lowpass_moving_average nlma_checker u_nlma_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
